>>> hdl/sifd_pkg.sv
`timescale 1ns / 1ps

package sifd_pkg;

    localparam int DEF_MAX_DELAY = 131072;
    localparam int DEF_SAMPLE_W  = 24;

    localparam int TARGET_W    = 17;
    localparam int FB_W        = 15;
    localparam int MIX_W       = 16;
    localparam int RAMP_W      = 16;
    localparam int FRAC_W      = 16;
    localparam int CUR_W       = TARGET_W + FRAC_W;
    localparam int STEP_W      = CUR_W + 1;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 17;
    localparam int CHAN_W      = 2;

    localparam logic [FB_W-1:0]  FB_MAX  = FB_W'(31130);
    localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(32768);

    localparam int RST_TARGET      = 24000;
    localparam int RST_FB_GAIN     = 16384;
    localparam int RST_MIX_LEVEL   = 16384;
    localparam int RST_RAMP_LENGTH = 2400;

    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_TARGET = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FB_GAIN      = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_MIX_LEVEL    = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_LENGTH  = CFG_INDEX_W'(3);

    typedef struct packed {
        logic take;
        logic adv;
        logic addr;
        logic read;
        logic mul1;
        logic wet;
        logic mul2;
        logic fin;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic ramp_busy;
        logic delayed;
    } sts_t;

endpackage

>>> hdl/sifd_div.sv
`timescale 1ns / 1ps

module sifd_div #(
    parameter int N = 33,
    parameter int M = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [M-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CNT_W = $clog2(N);

    logic [N-1:0]     work_reg;
    logic [M-1:0]     rem_reg;
    logic [M-1:0]     div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [M:0]   trial;
    logic         q_bit;
    logic [M-1:0] rem_next;

    always_comb begin
        trial = {rem_reg, work_reg[N-1]};
        q_bit = (trial >= {1'b0, div_reg});
        if (q_bit) begin
            rem_next = M'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[M-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            work_reg <= {work_reg[N-2:0], q_bit};
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

>>> hdl/sifd_datapath.sv
`timescale 1ns / 1ps

module sifd_datapath import sifd_pkg::*; #(
    parameter int MAX_DELAY = DEF_MAX_DELAY,
    parameter int SAMPLE_W  = DEF_SAMPLE_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic [CHAN_W-1:0]          s_channel,
    output logic signed [SAMPLE_W-1:0] m_sample_out
);

    localparam int ADDR_W = $clog2(MAX_DELAY);
    localparam int SAT_W  = SAMPLE_W + 19;
    localparam int P1_W   = SAMPLE_W + 18;
    localparam int FBP_W  = SAMPLE_W + 16;
    localparam int DRY_W  = SAMPLE_W + 18;
    localparam int WETP_W = SAMPLE_W + 17;

    localparam int TGT_LIMIT_I = (MAX_DELAY - 1 < (1 << TARGET_W) - 1) ?
                                 MAX_DELAY - 1 : (1 << TARGET_W) - 1;
    localparam logic [TARGET_W-1:0] TGT_LIMIT = TARGET_W'(TGT_LIMIT_I);
    localparam int RST_TGT_I = (RST_TARGET < TGT_LIMIT_I) ? RST_TARGET : TGT_LIMIT_I;
    localparam longint RST_STEP_L = (longint'(RST_TGT_I) * 65536) / RST_RAMP_LENGTH;

    localparam logic [31:0] DMAX = 32'(MAX_DELAY - 1);
    localparam logic [31:0] DEPTH = 32'(MAX_DELAY);

    localparam logic signed [P1_W-1:0]  RND16 = P1_W'(32768);
    localparam logic signed [FBP_W-1:0] RND_FB = FBP_W'(16384);
    localparam logic signed [SAT_W-1:0] RND_MIX = SAT_W'(16384);
    localparam logic signed [SAT_W-1:0] SMAX =
        SAT_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] SMIN = -SMAX - SAT_W'(1);

    function automatic logic signed [SAMPLE_W-1:0] sat_fn(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] r;
        begin
            if (v > SMAX) begin
                r = SMAX;
            end else if (v < SMIN) begin
                r = SMIN;
            end else begin
                r = v;
            end
            return r[SAMPLE_W-1:0];
        end
    endfunction

    // Configuration and ramp state.
    logic [TARGET_W-1:0]      target_reg;
    logic [FB_W-1:0]          fb_reg;
    logic [MIX_W-1:0]         mix_reg;
    logic [RAMP_W-1:0]        ramp_len_reg;
    logic [CUR_W-1:0]         cur_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic [RAMP_W-1:0]        rem_reg;
    logic                     pending_reg;
    logic                     neg_reg;

    // Line pointers.
    logic [ADDR_W-1:0] wp_l_reg;
    logic [ADDR_W-1:0] wp_r_reg;
    logic              full_l_reg;
    logic              full_r_reg;

    // Per-item payload.
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [CHAN_W-1:0]          ch_reg;
    logic [ADDR_W-1:0]          t1_reg;
    logic [ADDR_W-1:0]          t2_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic                       a_ok_reg;
    logic                       b_ok_reg;
    logic signed [SAMPLE_W-1:0] la_reg;
    logic signed [SAMPLE_W-1:0] lb_reg;
    logic signed [SAMPLE_W-1:0] ra_reg;
    logic signed [SAMPLE_W-1:0] rb_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [P1_W-1:0]     prod1_reg;
    logic signed [SAMPLE_W-1:0] wet_reg;
    logic signed [FBP_W-1:0]    fbp_reg;
    logic signed [DRY_W-1:0]    dryp_reg;
    logic signed [WETP_W-1:0]   wetp_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic signed [SAMPLE_W-1:0] left_line [MAX_DELAY];
    logic signed [SAMPLE_W-1:0] right_line [MAX_DELAY];

    logic [TARGET_W-1:0]      tgt_raw;
    logic [TARGET_W-1:0]      tgt_new;
    logic                     tgt_change;
    logic signed [STEP_W-1:0] diff;
    logic [CUR_W-1:0]         mag;
    logic                     div_start;
    logic                     div_done;
    logic [CUR_W-1:0]         div_q;
    logic [RAMP_W-1:0]        rem_dec;
    logic signed [STEP_W-1:0] cur_sum;
    logic [CUR_W-1:0]         goal;

    logic [ADDR_W-1:0]          wp_sel;
    logic                       full_sel;
    logic [31:0]                d32;
    logic [31:0]                wp32;
    logic [31:0]                t1_32;
    logic [ADDR_W-1:0]          t1;
    logic [ADDR_W-1:0]          t2;
    logic signed [SAMPLE_W-1:0] a_val;
    logic signed [SAMPLE_W-1:0] b_val;
    logic signed [SAMPLE_W:0]   tap_diff;
    logic signed [P1_W-1:0]     wet_full;
    logic [MIX_W:0]             dry_gain;
    logic signed [SAT_W-1:0]    fb_term;
    logic signed [SAT_W-1:0]    stored_full;
    logic signed [SAT_W-1:0]    mix_full;
    logic signed [SAMPLE_W-1:0] stored;

    always_comb begin
        tgt_raw = cfg_wr_data[TARGET_W-1:0];
        if (tgt_raw == '0) begin
            tgt_new = TARGET_W'(1);
        end else if (tgt_raw > TGT_LIMIT) begin
            tgt_new = TGT_LIMIT;
        end else begin
            tgt_new = tgt_raw;
        end
        tgt_change = cfg_wr_en && (cfg_index == REG_DELAY_TARGET) && (tgt_new != target_reg);
        diff = $signed({1'b0, tgt_new, {FRAC_W{1'b0}}}) - $signed({1'b0, cur_reg});
        if (diff[STEP_W-1]) begin
            mag = CUR_W'(-diff);
        end else begin
            mag = diff[CUR_W-1:0];
        end
        div_start = tgt_change && (ramp_len_reg != '0);
        rem_dec = rem_reg - 1'b1;
        cur_sum = $signed({1'b0, cur_reg}) + step_reg;
        goal = {target_reg, {FRAC_W{1'b0}}};
    end

    sifd_div #(
        .N(CUR_W),
        .M(RAMP_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(mag),
        .divisor (ramp_len_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= TARGET_W'(RST_TGT_I);
            fb_reg       <= FB_W'(RST_FB_GAIN);
            mix_reg      <= MIX_W'(RST_MIX_LEVEL);
            ramp_len_reg <= RAMP_W'(RST_RAMP_LENGTH);
            cur_reg      <= '0;
            step_reg     <= STEP_W'(RST_STEP_L);
            rem_reg      <= RAMP_W'(RST_RAMP_LENGTH);
            pending_reg  <= 1'b0;
            neg_reg      <= 1'b0;
        end else begin
            if (cmd.adv && rem_reg != '0) begin
                rem_reg <= rem_dec;
                if (rem_dec != '0) begin
                    cur_reg <= cur_sum[CUR_W-1:0];
                end else begin
                    cur_reg <= goal;
                end
            end
            if (div_done && pending_reg) begin
                pending_reg <= 1'b0;
                if (neg_reg) begin
                    step_reg <= -$signed({1'b0, div_q});
                end else begin
                    step_reg <= $signed({1'b0, div_q});
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DELAY_TARGET: begin
                        if (tgt_change) begin
                            target_reg <= tgt_new;
                            if (ramp_len_reg == '0) begin
                                cur_reg     <= {tgt_new, {FRAC_W{1'b0}}};
                                step_reg    <= '0;
                                rem_reg     <= '0;
                                pending_reg <= 1'b0;
                            end else begin
                                rem_reg     <= ramp_len_reg;
                                pending_reg <= 1'b1;
                                neg_reg     <= diff[STEP_W-1];
                            end
                        end
                    end
                    REG_FB_GAIN: begin
                        if (cfg_wr_data[FB_W-1:0] > FB_MAX) begin
                            fb_reg <= FB_MAX;
                        end else begin
                            fb_reg <= cfg_wr_data[FB_W-1:0];
                        end
                    end
                    REG_MIX_LEVEL: begin
                        if (cfg_wr_data[MIX_W-1:0] > MIX_ONE) begin
                            mix_reg <= MIX_ONE;
                        end else begin
                            mix_reg <= cfg_wr_data[MIX_W-1:0];
                        end
                    end
                    REG_RAMP_LENGTH: begin
                        ramp_len_reg <= cfg_wr_data[RAMP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        wp_sel   = ch_reg[0] ? wp_r_reg : wp_l_reg;
        full_sel = ch_reg[0] ? full_r_reg : full_l_reg;
        d32 = 32'(cur_reg[CUR_W-1:FRAC_W]);
        if (d32 > DMAX) begin
            d32 = DMAX;
        end
        wp32 = 32'(wp_sel);
        if (wp32 >= d32) begin
            t1_32 = wp32 - d32;
        end else begin
            t1_32 = wp32 + DEPTH - d32;
        end
        t1 = t1_32[ADDR_W-1:0];
        if (t1 == '0) begin
            t2 = DMAX[ADDR_W-1:0];
        end else begin
            t2 = t1 - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_l_reg   <= '0;
            wp_r_reg   <= '0;
            full_l_reg <= 1'b0;
            full_r_reg <= 1'b0;
        end else if (cmd.fin) begin
            if (ch_reg[0]) begin
                if (wp_r_reg == DMAX[ADDR_W-1:0]) begin
                    wp_r_reg   <= '0;
                    full_r_reg <= 1'b1;
                end else begin
                    wp_r_reg <= wp_r_reg + 1'b1;
                end
            end else begin
                if (wp_l_reg == DMAX[ADDR_W-1:0]) begin
                    wp_l_reg   <= '0;
                    full_l_reg <= 1'b1;
                end else begin
                    wp_l_reg <= wp_l_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            la_reg <= left_line[t1_reg];
            lb_reg <= left_line[t2_reg];
            ra_reg <= right_line[t1_reg];
            rb_reg <= right_line[t2_reg];
        end
        if (cmd.fin && !ch_reg[0]) begin
            left_line[wp_l_reg] <= stored;
        end
        if (cmd.fin && ch_reg[0]) begin
            right_line[wp_r_reg] <= stored;
        end
    end

    always_comb begin
        if (!a_ok_reg) begin
            a_val = '0;
        end else if (ch_reg[0]) begin
            a_val = ra_reg;
        end else begin
            a_val = la_reg;
        end
        if (!b_ok_reg) begin
            b_val = '0;
        end else if (ch_reg[0]) begin
            b_val = rb_reg;
        end else begin
            b_val = lb_reg;
        end
        tap_diff = (SAMPLE_W + 1)'(b_val) - (SAMPLE_W + 1)'(a_val);
        wet_full = P1_W'(a_reg) + ((prod1_reg + RND16) >>> FRAC_W);
        dry_gain = (MIX_W + 1)'({1'b0, MIX_ONE} - {1'b0, mix_reg});
        fb_term = SAT_W'((fbp_reg + RND_FB) >>> FB_W);
        stored_full = SAT_W'(x_reg) + fb_term;
        stored = sat_fn(stored_full);
        mix_full = (SAT_W'(dryp_reg) + SAT_W'(wetp_reg) + RND_MIX) >>> FB_W;
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            x_reg  <= s_sample_in;
            ch_reg <= s_channel;
        end
        if (cmd.addr) begin
            t1_reg   <= t1;
            t2_reg   <= t2;
            frac_reg <= cur_reg[FRAC_W-1:0];
        end
        if (cmd.read) begin
            a_ok_reg <= full_sel || (t1_reg < wp_sel);
            b_ok_reg <= full_sel || (t2_reg < wp_sel);
        end
        if (cmd.mul1) begin
            a_reg     <= a_val;
            prod1_reg <= $signed({1'b0, frac_reg}) * tap_diff;
        end
        if (cmd.wet) begin
            wet_reg <= wet_full[SAMPLE_W-1:0];
        end
        if (cmd.mul2) begin
            fbp_reg  <= wet_reg * $signed({1'b0, fb_reg});
            dryp_reg <= x_reg * $signed({1'b0, dry_gain});
            wetp_reg <= wet_reg * $signed({1'b0, mix_reg});
        end
        if (cmd.fin) begin
            y_reg <= sat_fn(mix_full);
        end
        if (cmd.load_out) begin
            out_reg <= ch_reg[1] ? x_reg : y_reg;
        end
    end

    assign sts.ramp_busy = pending_reg;
    assign sts.delayed   = !ch_reg[1];
    assign m_sample_out  = out_reg;

endmodule

>>> hdl/sifd_ctrl.sv
`timescale 1ns / 1ps

module sifd_ctrl import sifd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ADV  = 4'd1;
    localparam logic [3:0] ST_ADDR = 4'd2;
    localparam logic [3:0] ST_READ = 4'd3;
    localparam logic [3:0] ST_MUL1 = 4'd4;
    localparam logic [3:0] ST_WET  = 4'd5;
    localparam logic [3:0] ST_MUL2 = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = !sts.ramp_busy;
                if (s_valid && !sts.ramp_busy) begin
                    cmd.take   = 1'b1;
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                if (!sts.delayed) begin
                    state_next = ST_OUT;
                end else if (!sts.ramp_busy) begin
                    cmd.adv    = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_WET;
            end
            ST_WET: begin
                cmd.wet    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> hdl/stereo_interpolated_feedback_delay.sv
// Channel   Signals                              Transaction
// input     s_valid s_ready s_sample_in s_channel  s_valid and s_ready high at aclk
// result    m_valid m_ready m_sample_out           m_valid and m_ready high at aclk
// config    cfg_wr_en cfg_index cfg_wr_data        cfg_wr_en high at aclk
//
// A pass-through item (channel 2 or 3) goes from accept through advance to output, a
// delayed one (channel 0 or 1) through advance, address, read, mul1, wet, mul2, finish
// and output. A write that changes the delay target with a nonzero ramp length runs a
// 33-step serial divide for the ramp step, and no input is accepted until the step is
// loaded. Reset needs no clearing pass: unwritten line entries read as zero through fill
// pointers. A stalled result holds in the output register while the next input is taken.
`timescale 1ns / 1ps

module stereo_interpolated_feedback_delay import sifd_pkg::*; #(
    parameter int MAX_DELAY = DEF_MAX_DELAY,
    parameter int SAMPLE_W  = DEF_SAMPLE_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic [CHAN_W-1:0]          s_channel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data
);

    cmd_t cmd;
    sts_t sts;

    sifd_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .sts    (sts)
    );

    sifd_datapath #(
        .MAX_DELAY(MAX_DELAY),
        .SAMPLE_W (SAMPLE_W)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_sample_in (s_sample_in),
        .s_channel   (s_channel),
        .m_sample_out(m_sample_out)
    );

endmodule

>>> tb/stereo_interpolated_feedback_delay_tb.sv
`timescale 1ns / 1ps

module stereo_interpolated_feedback_delay_tb import sifd_pkg::*;;

    localparam int MAX_DELAY   = DEF_MAX_DELAY;
    localparam int SAMPLE_W    = DEF_SAMPLE_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 173;
    localparam int IDLE_PCT    = 14;

    localparam logic [CHAN_W-1:0] CH_LEFT   = CHAN_W'(0);
    localparam logic [CHAN_W-1:0] CH_RIGHT  = CHAN_W'(1);
    localparam logic [CHAN_W-1:0] CH_THRU_A = CHAN_W'(2);
    localparam logic [CHAN_W-1:0] CH_THRU_B = CHAN_W'(3);

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = CFG_INDEX_W'(132);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint CLIP_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint CLIP_LO = -CLIP_HI - 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          chan;
    } audio_txn_t;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in = '0;
    logic [CHAN_W-1:0]          s_channel   = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index   = '0;
    logic [CFG_DATA_W-1:0]      cfg_wr_data = '0;

    audio_txn_t                 pending_samples[$];
    logic signed [SAMPLE_W-1:0] expected_samples[$];
    logic signed [SAMPLE_W-1:0] want_sample;
    logic                       in_fire     = 1'b0;
    bit                         no_idle     = 1'b0;
    int                         items_queued    = 0;
    int                         results_checked = 0;
    int                         mismatch_count  = 0;
    int                         cycle_count     = 0;

    // Shadow of the block: both delay lines, pointers, the ramp and the registers.
    int     line_store [2][MAX_DELAY];
    longint write_ptr [2];
    longint cur_delay;
    longint ramp_inc;
    longint ramp_left;
    longint tgt_reg;
    longint fb_reg;
    longint mix_reg;
    longint ramp_len_reg;

    stereo_interpolated_feedback_delay dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .s_channel   (s_channel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample_out(m_sample_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint round_q(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip_sample(input longint v);
        if (v > CLIP_HI) return CLIP_HI;
        if (v < CLIP_LO) return CLIP_LO;
        return v;
    endfunction

    function automatic void start_delay_ramp();
        longint goal;
        goal = tgt_reg << 16;
        if (ramp_len_reg == 0) begin
            cur_delay = goal;
            ramp_inc  = 0;
            ramp_left = 0;
        end else begin
            ramp_inc  = (goal - cur_delay) / ramp_len_reg;
            ramp_left = ramp_len_reg;
        end
    endfunction

    function automatic void reset_delay_line();
        foreach (line_store[i, j]) line_store[i][j] = 0;
        write_ptr[0] = 0;
        write_ptr[1] = 0;
        tgt_reg      = RST_TARGET;
        fb_reg       = RST_FB_GAIN;
        mix_reg      = RST_MIX_LEVEL;
        ramp_len_reg = RST_RAMP_LENGTH;
        cur_delay    = 0;
        start_delay_ramp();
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        longint v;
        case (idx)
            REG_DELAY_TARGET: begin
                v = data[TARGET_W-1:0];
                if (v < 1) v = 1;
                if (v > MAX_DELAY - 1) v = MAX_DELAY - 1;
                if (v != tgt_reg) begin
                    tgt_reg = v;
                    start_delay_ramp();
                end
            end
            REG_FB_GAIN: begin
                v = data[FB_W-1:0];
                fb_reg = (v > longint'(FB_MAX)) ? longint'(FB_MAX) : v;
            end
            REG_MIX_LEVEL: begin
                v = data[MIX_W-1:0];
                mix_reg = (v > longint'(MIX_ONE)) ? longint'(MIX_ONE) : v;
            end
            REG_RAMP_LENGTH: begin
                ramp_len_reg = data[RAMP_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] delay_line_step(
            input logic signed [SAMPLE_W-1:0] sample, input logic [CHAN_W-1:0] chan);
        longint x, d, frac, a, b, wet, stored, mixed, t1, t2;
        int side;
        if (chan == CH_THRU_A || chan == CH_THRU_B) return sample;
        x = sample;
        side = (chan == CH_LEFT) ? 0 : 1;
        if (ramp_left != 0) begin
            ramp_left--;
            if (ramp_left != 0) begin
                cur_delay += ramp_inc;
            end else begin
                cur_delay = tgt_reg << 16;
            end
        end
        d = cur_delay >>> 16;
        frac = cur_delay & 64'hFFFF;
        if (d > MAX_DELAY - 1) d = MAX_DELAY - 1;
        t1 = (write_ptr[side] + MAX_DELAY - d) % MAX_DELAY;
        t2 = (t1 + MAX_DELAY - 1) % MAX_DELAY;
        a = line_store[side][t1];
        b = line_store[side][t2];
        wet = a + round_q(frac * (b - a), 16);
        stored = clip_sample(x + round_q(wet * fb_reg, 15));
        line_store[side][write_ptr[side]] = int'(stored);
        write_ptr[side] = (write_ptr[side] + 1) % MAX_DELAY;
        mixed = round_q(x * (longint'(MIX_ONE) - mix_reg) + wet * mix_reg, 15);
        return SAMPLE_W'(clip_sample(mixed));
    endfunction

    task automatic report_mismatch(input string what, input logic signed [SAMPLE_W-1:0] got,
                                   input logic signed [SAMPLE_W-1:0] want);
        $display("MISMATCH %s at cycle %0d: got %0d, expected %0d",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        apply_register(idx, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        // A new target with a nonzero ramp length starts the ramp-step divide; let it finish before anything else.
        if (idx == REG_DELAY_TARGET) repeat (40) @(negedge aclk);
    endtask

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] sample,
                                input logic [CHAN_W-1:0] chan);
        audio_txn_t txn;
        txn.sample = sample;
        txn.chan   = chan;
        pending_samples.push_back(txn);
        items_queued++;
    endtask

    task automatic settle();
        while (results_checked != items_queued) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 1) ? CH_RIGHT : CH_LEFT;
        return $urandom_range(0, 1) ? CH_THRU_B : CH_THRU_A;
    endfunction

    task automatic configure_phase(input int phase);
        logic [CFG_DATA_W-1:0] value;
        if (phase == 0 || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0: value = '0;
                1: value = CFG_DATA_W'(16'hFFFF);
                2: value = CFG_DATA_W'($urandom);
                default: value = CFG_DATA_W'($urandom_range(1, 40));
            endcase
            write_register(REG_RAMP_LENGTH, value);
        end
        if (phase == 1) begin
            write_register(REG_FB_GAIN, '0);
        end else if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0: value = '0;
                1: value = CFG_DATA_W'($urandom) | CFG_DATA_W'(15'h7FFF);
                2: value = CFG_DATA_W'($urandom);
                default: value = CFG_DATA_W'($urandom_range(0, 32767));
            endcase
            write_register(REG_FB_GAIN, value);
        end
        if (phase == 1) begin
            write_register(REG_MIX_LEVEL, '0);
        end else if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0: value = '0;
                1: value = CFG_DATA_W'(MIX_ONE);
                2: value = CFG_DATA_W'($urandom);
                default: value = CFG_DATA_W'($urandom_range(0, 32768));
            endcase
            write_register(REG_MIX_LEVEL, value);
        end
        if ($urandom_range(0, 4) == 0) begin
            write_register(CFG_INDEX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
        end
        if (phase == 2) begin
            write_register(REG_DELAY_TARGET, CFG_DATA_W'(MAX_DELAY - 1));
        end else begin
            case ($urandom_range(0, 9))
                0: value = CFG_DATA_W'(MAX_DELAY - 1);
                1: value = '0;
                2: value = CFG_DATA_W'($urandom);
                3: value = CFG_DATA_W'(tgt_reg);
                default: value = CFG_DATA_W'($urandom_range(1, 48));
            endcase
            write_register(REG_DELAY_TARGET, value);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_samples.size() > 0 &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_valid     <= 1'b1;
                s_sample_in <= pending_samples[0].sample;
                s_channel   <= pending_samples[0].chan;
                pending_samples.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                expected_samples.push_back(delay_line_step(s_sample_in, s_channel));
            end
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected transaction", m_sample_out, '0);
                end else begin
                    want_sample = expected_samples.pop_front();
                    results_checked++;
                    if (m_sample_out !== want_sample) begin
                        report_mismatch("sample_out", m_sample_out, want_sample);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stereo_interpolated_feedback_delay_tb failed");
            $finish;
        end
    end

    initial begin
        reset_delay_line();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Short ramp from zero to one sample, so the first taps sit at zero whole delay.
        write_register(REG_RAMP_LENGTH, CFG_DATA_W'(8));
        write_register(REG_FB_GAIN, '1);
        write_register(REG_MIX_LEVEL, '1);
        write_register(REG_UNUSED_TOP, '1);
        write_register(REG_UNUSED_LOW, '0);
        write_register(REG_DELAY_TARGET, '0);
        queue_sample(SAMPLE_MAX, CH_LEFT);
        queue_sample(SAMPLE_MAX, CH_LEFT);
        queue_sample(SAMPLE_MIN, CH_LEFT);
        queue_sample(SAMPLE_MIN, CH_LEFT);
        queue_sample('0, CH_LEFT);
        queue_sample(SAMPLE_W'(1), CH_LEFT);
        queue_sample('1, CH_LEFT);
        queue_sample(SAMPLE_MAX, CH_LEFT);
        queue_sample(SAMPLE_MIN, CH_RIGHT);
        queue_sample(SAMPLE_MAX, CH_RIGHT);
        queue_sample(SAMPLE_MIN, CH_RIGHT);
        queue_sample(SAMPLE_W'(12345), CH_RIGHT);
        queue_sample(SAMPLE_MAX, CH_THRU_A);
        queue_sample(SAMPLE_MIN, CH_THRU_A);
        queue_sample('1, CH_THRU_B);
        queue_sample('0, CH_THRU_B);
        settle();

        // Rewriting the held target must not restart the ramp; with no ramp length
        // the next new target is taken at once.
        write_register(REG_RAMP_LENGTH, '0);
        write_register(REG_FB_GAIN, '0);
        write_register(REG_MIX_LEVEL, '0);
        write_register(REG_DELAY_TARGET, CFG_DATA_W'(1));
        write_register(REG_DELAY_TARGET, CFG_DATA_W'(5));
        queue_sample(SAMPLE_MAX, CH_LEFT);
        queue_sample(SAMPLE_MIN, CH_RIGHT);
        queue_sample(SAMPLE_W'(-4096), CH_LEFT);
        queue_sample(SAMPLE_W'(77), CH_RIGHT);
        queue_sample(SAMPLE_MAX, CH_LEFT);
        queue_sample(SAMPLE_MIN, CH_RIGHT);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            configure_phase(phase);
            no_idle = (phase == 4);
            repeat (PHASE_ITEMS) queue_sample(pick_sample(), pick_channel());
            settle();
        end

        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("stereo_interpolated_feedback_delay_tb passed");
        end else begin
            $display("stereo_interpolated_feedback_delay_tb failed");
        end
        $finish;
    end

endmodule
